// ===== src/rsn_pkg.sv =====
// rsn_pkg: shared types, constants and microcode rom for the rustle noise generator
`default_nettype none

package rsn_pkg;

  // fixed-point constants and reset values
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [17:0] GAIN_COEF   = 18'd9830;
  localparam logic [17:0] ALPHA_COEF  = 18'd6554;
  localparam logic [15:0] ALPHA_BASE  = 16'd1311;
  localparam logic [31:0] SEED_RESET  = 32'd135792468;
  localparam logic [15:0] GATE_RESET  = 16'd7;

  // program counter of the sequencer
  typedef logic [3:0] pc_t;

  localparam pc_t PC_UPDATE = 4'd0;
  localparam pc_t PC_SAMPLE = 4'd5;
  localparam pc_t PC_MUTED  = 4'd9;

  // multiplier operand a
  typedef enum logic [2:0] {
    A_ZERO,
    A_STRENGTH,
    A_PROD,
    A_GDIFF,
    A_ADIFF,
    A_LPDIFF
  } mul_a_t;

  // multiplier operand b
  typedef enum logic [2:0] {
    B_ZERO,
    B_DENS,
    B_GAINCOEF,
    B_RATE,
    B_ALPHACOEF,
    B_DT,
    B_ALPHA,
    B_GAIN
  } mul_b_t;

  // product writeback target
  typedef enum logic [2:0] {
    WB_NONE,
    WB_T,
    WB_TGAIN,
    WB_GAIN,
    WB_TALPHA,
    WB_ALPHA,
    WB_LOW
  } wb_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PROD,
    EMIT_ZERO
  } emit_t;

  typedef enum logic {
    JMP_NONE,
    JMP_GATED
  } jmp_t;

  typedef struct packed {
    mul_a_t a_sel;
    mul_b_t b_sel;
    wb_t    wb;
    logic   noise;
    emit_t  emit;
    jmp_t   jmp;
    pc_t    target;
    logic   last;
  } cw_t;

  // sequencer to datapath
  typedef struct packed {
    cw_t  cw;
    logic step_en;
    logic load;
  } rsn_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic gated;
    logic out_busy;
  } rsn_stat_t;

  // microcode rom
  function automatic cw_t rsn_rom(input pc_t pc);
    cw_t w;
    w = '{a_sel: A_ZERO, b_sel: B_ZERO, wb: WB_NONE, noise: 1'b0, emit: EMIT_NONE,
          jmp: JMP_NONE, target: PC_UPDATE, last: 1'b0};
    case (pc)
      // update: target gain
      4'd0: begin
        w.a_sel = A_STRENGTH;
        w.b_sel = B_DENS;
        w.wb    = WB_T;
      end
      4'd1: begin
        w.a_sel = A_PROD;
        w.b_sel = B_GAINCOEF;
        w.wb    = WB_TGAIN;
      end
      4'd2: begin
        w.a_sel = A_GDIFF;
        w.b_sel = B_RATE;
        w.wb    = WB_GAIN;
      end
      // update: target alpha
      4'd3: begin
        w.a_sel = A_STRENGTH;
        w.b_sel = B_ALPHACOEF;
        w.wb    = WB_TALPHA;
      end
      4'd4: begin
        w.a_sel = A_ADIFF;
        w.b_sel = B_DT;
        w.wb    = WB_ALPHA;
        w.last  = 1'b1;
      end
      // sample: gate check
      4'd5: begin
        w.jmp    = JMP_GATED;
        w.target = PC_MUTED;
      end
      4'd6: begin
        w.noise = 1'b1;
      end
      4'd7: begin
        w.a_sel = A_LPDIFF;
        w.b_sel = B_ALPHA;
        w.wb    = WB_LOW;
      end
      4'd8: begin
        w.a_sel = A_LPDIFF;
        w.b_sel = B_GAIN;
        w.emit  = EMIT_PROD;
        w.last  = 1'b1;
      end
      4'd9: begin
        w.emit = EMIT_ZERO;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/rustle_noise_generator_top.sv =====
// rustle_noise_generator_top: top level of the rustle noise generator
`default_nettype none

// rustle noise generator. each input item is either a sample request (mode 0) or a
// parameter update (mode 1). a sample item steps a xorshift32 generator, takes its top
// 16 bits as white noise in q1.15, subtracts a one-pole low-pass of it, scales the
// result by the current gain and saturates to 16 bits; one output item per sample item,
// with end_of_block copied to block_end. while the gain is at or below gate_threshold
// the output is zero and neither the generator nor the filter moves. an update item
// derives target gain and alpha from wind strength and grass density and moves the
// current values toward them by delta time; it produces no output item.
// timing: control is a ten-word microcode program driving one shared 34x18 multiplier,
// one product per cycle unless an emitting step waits on the output register. an update
// item runs 5 steps and a sample item 4 (2 when muted, since the gate check jumps
// straight to the zero word). the item is latched when taken, and the next item is only
// accepted after the final step of the current one. the finished sample sits in an
// output register, so a new item can be taken while it waits; the final step of the
// next sample holds until that register is free. gate_threshold resets to 7 and may be
// written at any idle time through cfg_wr_en / cfg_wr_data.

module rustle_noise_generator_top (
  input  wire               clk,
  input  wire               rst_n,
  // configuration
  input  wire               cfg_wr_en,
  input  wire  [15:0]       cfg_wr_data,
  // input items
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_mode,
  input  wire  [15:0]       in_wind_strength,
  input  wire  [15:0]       in_grass_density,
  input  wire  [15:0]       in_delta_time,
  input  wire               in_end_of_block,
  // output items
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_sample,
  output logic              out_block_end
);

  rsn_pkg::rsn_ctrl_t ctrl;
  rsn_pkg::rsn_stat_t stat;

  // step counter and microcode rom
  rsn_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // multiplier, state registers and output register
  rsn_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_wind_strength (in_wind_strength),
    .in_grass_density (in_grass_density),
    .in_delta_time    (in_delta_time),
    .in_end_of_block  (in_end_of_block),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample       (out_sample),
    .out_block_end    (out_block_end)
  );

endmodule

`default_nettype wire

// ===== src/rsn_sequencer.sv =====
// rsn_sequencer: step counter, microcode fetch and conditional jump
`default_nettype none

module rsn_sequencer (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_mode,
  output logic             in_stall,
  input  rsn_pkg::rsn_stat_t stat,
  output rsn_pkg::rsn_ctrl_t ctrl
);

  logic          busy_r, busy_nxt;
  rsn_pkg::pc_t  pc_r, pc_nxt;
  rsn_pkg::cw_t  cw;
  logic          load;
  logic          step_en;

  assign cw       = rsn_pkg::rsn_rom(pc_r);
  assign in_stall = busy_r;
  assign load     = in_valid && !busy_r;
  // an emitting step waits while the output register is still held
  assign step_en  = busy_r && !((cw.emit != rsn_pkg::EMIT_NONE) && stat.out_busy);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (load) begin
      busy_nxt = 1'b1;
      pc_nxt   = in_mode ? rsn_pkg::PC_UPDATE : rsn_pkg::PC_SAMPLE;
    end else if (step_en) begin
      if ((cw.jmp == rsn_pkg::JMP_GATED) && stat.gated) begin
        pc_nxt = cw.target;
      end else if (cw.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= rsn_pkg::PC_UPDATE;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl.cw      = cw;
  assign ctrl.step_en = step_en;
  assign ctrl.load    = load;

endmodule

`default_nettype wire

// ===== src/rsn_datapath.sv =====
// rsn_datapath: shared multiplier, filter and gain state, noise generator, output register
`default_nettype none

module rsn_datapath (
  input  wire                clk,
  input  wire                rst_n,
  input  rsn_pkg::rsn_ctrl_t ctrl,
  input  wire  [15:0]        in_wind_strength,
  input  wire  [15:0]        in_grass_density,
  input  wire  [15:0]        in_delta_time,
  input  wire                in_end_of_block,
  input  wire                cfg_wr_en,
  input  wire  [15:0]        cfg_wr_data,
  output rsn_pkg::rsn_stat_t stat,
  input  wire                out_stall,
  output logic               out_valid,
  output logic signed [15:0] out_sample,
  output logic               out_block_end
);

  // latched item
  logic [15:0] wind_r, dens_r, dt_r;
  logic        eob_r;

  // state
  logic [15:0]        thr_r;
  logic [31:0]        seed_r;
  logic signed [17:0] low_r;
  logic [15:0]        gain_r, alpha_r;

  // scratch
  logic [32:0]        t_r;
  logic [15:0]        tg_r, ta_r;
  logic signed [15:0] white_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_sample_r;
  logic               out_block_end_r;

  logic [18:0]        wind_x8;
  logic [16:0]        strength;
  logic [16:0]        dt_x2;
  logic [16:0]        rate;
  logic signed [16:0] gdiff, adiff;
  logic signed [18:0] lpdiff;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [35:0] prod_sh;
  logic signed [36:0] acc_base, acc;
  logic [15:0]        acc_u16;
  logic signed [17:0] acc_s18;
  logic signed [15:0] prod_s16;
  logic [31:0]        xs1, xs2, xs3;
  logic               wr;

  assign wr = ctrl.step_en;

  // strength = wind * 8 clamped at one, rate = dt * 2 clamped at one
  assign wind_x8  = {wind_r, 3'b000};
  assign strength = (wind_x8 > {2'b00, rsn_pkg::ONE_Q16}) ? rsn_pkg::ONE_Q16 : wind_x8[16:0];
  assign dt_x2    = {dt_r, 1'b0};
  assign rate     = (dt_x2 > rsn_pkg::ONE_Q16) ? rsn_pkg::ONE_Q16 : dt_x2;

  assign gdiff  = $signed({1'b0, tg_r}) - $signed({1'b0, gain_r});
  assign adiff  = $signed({1'b0, ta_r}) - $signed({1'b0, alpha_r});
  assign lpdiff = $signed({{3{white_r[15]}}, white_r}) - $signed({low_r[17], low_r});

  always_comb begin
    case (ctrl.cw.a_sel)
      rsn_pkg::A_STRENGTH: mul_a = $signed({17'd0, strength});
      rsn_pkg::A_PROD:     mul_a = $signed({1'b0, t_r});
      rsn_pkg::A_GDIFF:    mul_a = $signed({{17{gdiff[16]}}, gdiff});
      rsn_pkg::A_ADIFF:    mul_a = $signed({{17{adiff[16]}}, adiff});
      rsn_pkg::A_LPDIFF:   mul_a = $signed({{15{lpdiff[18]}}, lpdiff});
      default:             mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.cw.b_sel)
      rsn_pkg::B_DENS:      mul_b = $signed({2'b00, dens_r});
      rsn_pkg::B_GAINCOEF:  mul_b = $signed(rsn_pkg::GAIN_COEF);
      rsn_pkg::B_RATE:      mul_b = $signed({1'b0, rate});
      rsn_pkg::B_ALPHACOEF: mul_b = $signed(rsn_pkg::ALPHA_COEF);
      rsn_pkg::B_DT:        mul_b = $signed({2'b00, dt_r});
      rsn_pkg::B_ALPHA:     mul_b = $signed({2'b00, alpha_r});
      rsn_pkg::B_GAIN:      mul_b = $signed({2'b00, gain_r});
      default:              mul_b = '0;
    endcase
  end

  assign prod    = mul_a * mul_b;
  // arithmetic shift, rounds toward minus infinity
  assign prod_sh = prod[51:16];

  always_comb begin
    case (ctrl.cw.wb)
      rsn_pkg::WB_GAIN:  acc_base = $signed({21'd0, gain_r});
      rsn_pkg::WB_ALPHA: acc_base = $signed({21'd0, alpha_r});
      rsn_pkg::WB_LOW:   acc_base = $signed({{19{low_r[17]}}, low_r});
      default:           acc_base = '0;
    endcase
  end

  assign acc = acc_base + $signed({prod_sh[35], prod_sh});

  // clamp to 0..65535
  always_comb begin
    if (acc[36]) begin
      acc_u16 = 16'd0;
    end else if (|acc[35:16]) begin
      acc_u16 = 16'hFFFF;
    end else begin
      acc_u16 = acc[15:0];
    end
  end

  // clamp to 18-bit signed
  always_comb begin
    if ((&acc[36:17]) || !(|acc[36:17])) begin
      acc_s18 = acc[17:0];
    end else begin
      acc_s18 = acc[36] ? 18'sh20000 : 18'sh1FFFF;
    end
  end

  // clamp to 16-bit signed
  always_comb begin
    if ((&prod_sh[35:15]) || !(|prod_sh[35:15])) begin
      prod_s16 = prod_sh[15:0];
    end else begin
      prod_s16 = prod_sh[35] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  // xorshift32 with shifts 13, 17, 5
  assign xs1 = seed_r ^ (seed_r << 13);
  assign xs2 = xs1 ^ (xs1 >> 17);
  assign xs3 = xs2 ^ (xs2 << 5);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wind_r <= in_wind_strength;
      dens_r <= in_grass_density;
      dt_r   <= in_delta_time;
      eob_r  <= in_end_of_block;
    end
    if (wr) begin
      case (ctrl.cw.wb)
        rsn_pkg::WB_T:      t_r  <= prod[32:0];
        rsn_pkg::WB_TGAIN:  tg_r <= prod[47:32];
        rsn_pkg::WB_TALPHA: ta_r <= rsn_pkg::ALPHA_BASE + prod[31:16];
        default: begin
        end
      endcase
      if (ctrl.cw.noise) begin
        white_r <= $signed({~xs3[31], xs3[30:16]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= rsn_pkg::GATE_RESET;
      seed_r  <= rsn_pkg::SEED_RESET;
      low_r   <= '0;
      gain_r  <= '0;
      alpha_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (wr) begin
        if (ctrl.cw.noise) begin
          seed_r <= xs3;
        end
        case (ctrl.cw.wb)
          rsn_pkg::WB_GAIN:  gain_r  <= acc_u16;
          rsn_pkg::WB_ALPHA: alpha_r <= acc_u16;
          rsn_pkg::WB_LOW:   low_r   <= acc_s18;
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (wr && (ctrl.cw.emit != rsn_pkg::EMIT_NONE)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && (ctrl.cw.emit != rsn_pkg::EMIT_NONE)) begin
      out_sample_r    <= (ctrl.cw.emit == rsn_pkg::EMIT_PROD) ? prod_s16 : 16'sd0;
      out_block_end_r <= eob_r;
    end
  end

  assign stat.gated    = (gain_r <= thr_r);
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_block_end = out_block_end_r;

endmodule

`default_nettype wire
